// ===== src/ebd_pkg.sv =====
// ----------------------------------------------------------------------------
// ebd_pkg
// Shared widths, register indexes, reset values and control types for the
// energy beat detector.
// ----------------------------------------------------------------------------
package ebd_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int ENERGY_W   = 16;
    localparam int OFFSET_W   = 18;
    localparam int SLOPE_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int VAR_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SLOPE  = 1'd1;

    localparam logic [OFFSET_W-1:0]       OFFSET_RESET = 18'd88474;
    localparam logic signed [SLOPE_W-1:0] SLOPE_RESET  = -32'sd1104408;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prod;
        logic div_start;
        logic sens_mul;
        logic sens_add;
        logic rhs_mul;
        logic commit;
    } ebd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } ebd_sts_t;

endpackage

// ===== src/ebd_div.sv =====
// ----------------------------------------------------------------------------
// ebd_div
// Divider by a fixed power of two: the dividend shifted right, registered on
// start.
// ----------------------------------------------------------------------------
module ebd_div #(
    parameter int DIVIDEND_W = 22,
    parameter int QUOTIENT_W = 16,
    parameter int SHIFT      = 6
) (
    input  logic                  clk,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic [QUOTIENT_W-1:0] quotient
);

    logic [QUOTIENT_W-1:0] quot_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend[SHIFT +: QUOTIENT_W];
        end
    end

    assign quotient = quot_reg;

endmodule

// ===== src/ebd_datapath.sv =====
// ----------------------------------------------------------------------------
// ebd_datapath
// Energy history ring, running sums, mean and variance dividers, sensitivity
// arithmetic, beat compare and the result register.
// ----------------------------------------------------------------------------
module ebd_datapath #(
    parameter int HISTORY_DEPTH = ebd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ebd_pkg::ebd_cmd_t                    cmd,
    output ebd_pkg::ebd_sts_t                    sts,
    input  logic [ebd_pkg::ENERGY_W-1:0]         frame_energy,
    input  logic [ebd_pkg::OFFSET_W-1:0]         offset,
    input  logic signed [ebd_pkg::SLOPE_W-1:0]   slope,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 beat_found,
    output logic [ebd_pkg::ENERGY_W-1:0]         mean_energy
);

    localparam int EW      = ebd_pkg::ENERGY_W;
    localparam int LOG_N   = $clog2(HISTORY_DEPTH);
    localparam int PTR_W   = LOG_N;
    localparam int SUM_W   = EW + LOG_N;
    localparam int SQ_W    = 2 * EW + LOG_N;
    localparam int NUM_W   = 2 * EW + 2 * LOG_N;
    localparam int VAR_W   = ebd_pkg::VAR_W;
    localparam int PROD_W  = ebd_pkg::SLOPE_W + VAR_W + 1;
    localparam int SENS_W  = PROD_W - 16 + 1;
    localparam int RHS_W   = EW + 1 + SENS_W;
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(HISTORY_DEPTH - 1);

    // history ring
    logic [EW-1:0] ring_mem [HISTORY_DEPTH];
    logic [EW-1:0] rd_data_reg;

    logic [PTR_W-1:0] ptr_reg;
    logic             wrapped_reg;
    logic [SUM_W-1:0] energy_sum_reg;
    logic [SQ_W-1:0]  square_sum_reg;

    logic [EW-1:0]               energy_reg;
    logic [EW-1:0]               old_reg;
    logic [2*EW-1:0]             old_sq_reg;
    logic [2*EW-1:0]             new_sq_reg;
    logic [NUM_W-1:0]            num_a_reg;
    logic [NUM_W-1:0]            num_b_reg;
    logic [NUM_W-1:0]            var_dividend;
    logic [EW-1:0]               mean_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [SENS_W-1:0]    sens_reg;
    logic signed [RHS_W-1:0]     rhs_reg;
    logic signed [EW+16:0]       lhs;

    logic                        out_valid_reg;
    logic                        beat_reg;
    logic [EW-1:0]               mean_out_reg;

    logic [EW-1:0]               mean_quot;
    logic [VAR_W-1:0]            var_quot;

    assign var_dividend = (num_a_reg > num_b_reg) ? (num_a_reg - num_b_reg) : '0;

    // depth is a power of two, so both divisions are shifts
    ebd_div #(
        .DIVIDEND_W (SUM_W),
        .QUOTIENT_W (EW),
        .SHIFT      (LOG_N)
    ) u_mean_div (
        .clk      (clk),
        .start    (cmd.div_start),
        .dividend (energy_sum_reg),
        .quotient (mean_quot)
    );

    ebd_div #(
        .DIVIDEND_W (NUM_W),
        .QUOTIENT_W (VAR_W),
        .SHIFT      (2 * LOG_N)
    ) u_var_div (
        .clk      (clk),
        .start    (cmd.div_start),
        .dividend (var_dividend),
        .quotient (var_quot)
    );

    assign lhs = $signed({1'b0, energy_reg, 16'b0});

    // ring memory, registered read at the current pointer
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            ring_mem[ptr_reg] <= energy_reg;
        end
        rd_data_reg <= ring_mem[ptr_reg];
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            energy_reg <= frame_energy;
        end
        if (cmd.prod)
        begin
            num_a_reg <= {square_sum_reg, {LOG_N{1'b0}}};
            num_b_reg <= NUM_W'(energy_sum_reg) * NUM_W'(energy_sum_reg);
            // entries not yet written since reset read as zero
            old_reg   <= wrapped_reg ? rd_data_reg : '0;
        end
        if (cmd.div_start)
        begin
            old_sq_reg <= old_reg * old_reg;
            new_sq_reg <= energy_reg * energy_reg;
        end
        if (cmd.sens_mul)
        begin
            mean_reg <= mean_quot;
            prod_reg <= slope * $signed({1'b0, var_quot});
        end
        if (cmd.sens_add)
        begin
            // arithmetic shift floors toward minus infinity
            sens_reg <= SENS_W'(prod_reg >>> 16) + $signed(SENS_W'(offset));
        end
        if (cmd.rhs_mul)
        begin
            rhs_reg <= $signed({1'b0, mean_reg}) * sens_reg;
        end
        if (cmd.commit)
        begin
            beat_reg     <= (lhs > rhs_reg);
            mean_out_reg <= mean_reg;
        end
    end

    // history state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            wrapped_reg    <= 1'b0;
            energy_sum_reg <= '0;
            square_sum_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                energy_sum_reg <= energy_sum_reg - SUM_W'(old_reg) + SUM_W'(energy_reg);
                square_sum_reg <= square_sum_reg - SQ_W'(old_sq_reg) + SQ_W'(new_sq_reg);
                if (ptr_reg == PTR_MAX)
                begin
                    ptr_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_busy = out_valid_reg & ~out_ready;

    assign out_valid   = out_valid_reg;
    assign beat_found  = beat_reg;
    assign mean_energy = mean_out_reg;

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten before it was taken");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_depth_pow2: assert property (@(posedge clk)
        HISTORY_DEPTH == (1 << LOG_N))
        else $error("history depth is not a power of two");

    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(ptr_reg))
        else $error("ring pointer moved without commit");
`endif

endmodule

// ===== src/ebd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ebd_ctrl
// Sequencer for one request: fetch, divide, sensitivity, compare, commit.
// ----------------------------------------------------------------------------
module ebd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ebd_pkg::ebd_sts_t sts,
    output ebd_pkg::ebd_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_DSTART,
        S_SMUL,
        S_SADD,
        S_RHS,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_SMUL;
            end
            S_SMUL:
            begin
                cmd.sens_mul = 1'b1;
                state_next   = S_SADD;
            end
            S_SADD:
            begin
                cmd.sens_add = 1'b1;
                state_next   = S_RHS;
            end
            S_RHS:
            begin
                cmd.rhs_mul = 1'b1;
                state_next  = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== src/energy_beat_detector_top.sv =====
// ----------------------------------------------------------------------------
// energy_beat_detector_top
// Frame energy beat detector: windowed mean and variance over the last
// HISTORY_DEPTH energies, variance-scaled threshold, one result per request.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     frame_energy
//   out      out_valid / out_ready   beat_found, mean_energy
//   cfg      cfg_write               cfg_index, cfg_data
//
// A request runs through the step sequence: load, products, shift divide and
// squares, slope multiply, offset add, mean multiply, commit; the next request
// is accepted only after commit. The result shows as in_ready returns.
// HISTORY_DEPTH must be a power of two.
// After reset the history reads as zero; no clearing pass is needed.
// A result waiting on out_ready holds the commit step, and in_ready with it.
// ----------------------------------------------------------------------------
module energy_beat_detector_top #(
    parameter int HISTORY_DEPTH = ebd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ebd_pkg::ENERGY_W-1:0]      frame_energy,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              beat_found,
    output logic [ebd_pkg::ENERGY_W-1:0]      mean_energy,
    input  logic                              cfg_write,
    input  logic [ebd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ebd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [ebd_pkg::OFFSET_W-1:0]       offset_reg;
    logic signed [ebd_pkg::SLOPE_W-1:0] slope_reg;
    ebd_pkg::ebd_cmd_t                  cmd;
    ebd_pkg::ebd_sts_t                  sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= ebd_pkg::OFFSET_RESET;
            slope_reg  <= ebd_pkg::SLOPE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ebd_pkg::CFG_IDX_OFFSET:
                begin
                    offset_reg <= cfg_data[ebd_pkg::OFFSET_W-1:0];
                end
                ebd_pkg::CFG_IDX_SLOPE:
                begin
                    slope_reg <= $signed(cfg_data[ebd_pkg::SLOPE_W-1:0]);
                end
                default:
                begin
                    offset_reg <= offset_reg;
                end
            endcase
        end
    end

    ebd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ebd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .frame_energy (frame_energy),
        .offset       (offset_reg),
        .slope        (slope_reg),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .beat_found   (beat_found),
        .mean_energy  (mean_energy)
    );

endmodule
